// File: rtl/core/dsq_pkg.sv
// dsq_pkg: shared types and constants of the delta-list sleep queue
// used by dsq_front, dsq_back and delta_sleep_queue; no dependencies
`default_nettype none

package dsq_pkg;

  localparam int TID_W       = 8;
  localparam int TICKS_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic FUNC_SLEEP  = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_WAKE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // request handed from the front end to the back end
  typedef struct packed {
    logic               func;
    logic [TID_W-1:0]   tid;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_APPEND,
    ST_INS_NEXT,
    ST_INS_POS,
    ST_ACK,
    ST_TK_HEAD,
    ST_TK_SCAN,
    ST_TK_LAST
  } st_t;

endpackage

`default_nettype wire

// File: rtl/core/dsq_ram.sv
// dsq_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`default_nettype none

module dsq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dsq_front.sv
// dsq_front: input acceptance, request classification and a two-word queue
// depends on dsq_pkg
`default_nettype none

module dsq_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [dsq_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  output      logic                              cmd_valid,
  input  wire logic                              cmd_ready,
  output      dsq_pkg::cmd_t                     cmd
);

  dsq_pkg::cmd_t   q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  dsq_pkg::cmd_t   in_cmd;
  logic            push, pop;

  // a zero-tick sleep counts as one tick
  always_comb begin
    in_cmd.func  = in_tuser;
    in_cmd.tid   = in_tdata[dsq_pkg::TID_W-1:0];
    in_cmd.ticks = in_tdata[dsq_pkg::IN_TDATA_W-1:dsq_pkg::TID_W];
    if (in_cmd.ticks == '0) begin
      in_cmd.ticks = dsq_pkg::TICKS_W'(1);
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dsq_back.sv
// dsq_back: delta-list engine; walks the entry RAM to insert and release sleepers
// depends on dsq_pkg and dsq_ram
`default_nettype none

module dsq_back #(
  parameter int MAX_SLEEPERS = 16,
  parameter int DELAY_WIDTH  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_valid,
  output      logic                  cmd_ready,
  input  wire dsq_pkg::cmd_t         cmd,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_kind,
  output      logic                  out_status,
  output      logic [dsq_pkg::TID_W-1:0] out_thread,
  output      logic                  out_last
);

  localparam int N  = MAX_SLEEPERS;
  localparam int DW = DELAY_WIDTH;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int EW = (DW > dsq_pkg::TICKS_W) ? DW : dsq_pkg::TICKS_W;
  localparam int RW = dsq_pkg::TID_W + DW;

  // logical position relative to the head, wrapped into the ring
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                            input logic [AW:0]   l);
    logic [AW:0] s;
    s = {1'b0, base} + l;
    if (s >= (AW+1)'(N)) begin
      s = s - (AW+1)'(N);
    end
    return s[AW-1:0];
  endfunction

  dsq_pkg::st_t           st_r, st_nxt;
  logic [CW-1:0]          occ_r, occ_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [DW-1:0]          sum_r, sum_nxt;
  logic [DW-1:0]          prev_r, prev_nxt;
  logic [DW-1:0]          t_r, t_nxt;
  logic [dsq_pkg::TID_W-1:0] tid_r, tid_nxt;
  logic [dsq_pkg::TID_W-1:0] hold_r, hold_nxt;
  logic                   full_r, full_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic                   out_status_r, out_status_nxt;
  logic [dsq_pkg::TID_W-1:0] out_thread_r, out_thread_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_load;

  logic                   rd_en, wr_en;
  logic [CW-1:0]          rd_log, wr_log;
  logic [RW-1:0]          wr_data, rdata;
  logic [DW-1:0]          rd_delta, sum_add, head_dec, cmd_t_sat;
  logic [dsq_pkg::TID_W-1:0] rd_thr;
  logic                   found, last_scan, more, out_free;
  logic [CW-1:0]          cand;
  logic [EW-1:0]          ticks_e;

  assign rd_delta  = rdata[DW-1:0];
  assign rd_thr    = rdata[RW-1:DW];
  assign sum_add   = sum_r + rd_delta;
  assign found     = (sum_add >= t_r);
  assign last_scan = ((idx_r + CW'(1)) == occ_r);
  assign head_dec  = (rd_delta == '0) ? '0 : rd_delta - DW'(1);
  assign cand      = idx_r + CW'(1);
  assign more      = (cand < occ_r) && (32'(cand) < 32'(dsq_pkg::MAX_RESULTS));
  assign out_free  = !out_valid_r || out_ready;
  assign ticks_e   = EW'(cmd.ticks);
  assign cmd_t_sat = (ticks_e > EW'({DW{1'b1}})) ? {DW{1'b1}} : ticks_e[DW-1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dsq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == dsq_pkg::FUNC_TICK) begin
            st_nxt = (occ_r == '0) ? dsq_pkg::ST_IDLE : dsq_pkg::ST_TK_HEAD;
          end else if (occ_r == CW'(N)) begin
            st_nxt = dsq_pkg::ST_ACK;
          end else if (occ_r == '0) begin
            st_nxt = dsq_pkg::ST_APPEND;
          end else begin
            st_nxt = dsq_pkg::ST_SCAN;
          end
        end
      end
      dsq_pkg::ST_SCAN: begin
        if (found) begin
          st_nxt = last_scan ? dsq_pkg::ST_INS_NEXT : dsq_pkg::ST_SHIFT;
        end else if (last_scan) begin
          st_nxt = dsq_pkg::ST_APPEND;
        end
      end
      dsq_pkg::ST_SHIFT: begin
        if (idx_r <= pos_r + CW'(2)) begin
          st_nxt = dsq_pkg::ST_INS_NEXT;
        end
      end
      dsq_pkg::ST_APPEND:   st_nxt = dsq_pkg::ST_ACK;
      dsq_pkg::ST_INS_NEXT: st_nxt = dsq_pkg::ST_INS_POS;
      dsq_pkg::ST_INS_POS:  st_nxt = dsq_pkg::ST_ACK;
      dsq_pkg::ST_ACK: begin
        if (out_free) begin
          st_nxt = dsq_pkg::ST_IDLE;
        end
      end
      dsq_pkg::ST_TK_HEAD: begin
        if (head_dec != '0) begin
          st_nxt = dsq_pkg::ST_IDLE;
        end else begin
          st_nxt = more ? dsq_pkg::ST_TK_SCAN : dsq_pkg::ST_TK_LAST;
        end
      end
      dsq_pkg::ST_TK_SCAN: begin
        if (out_free) begin
          if (rd_delta != '0) begin
            st_nxt = dsq_pkg::ST_IDLE;
          end else if (!more) begin
            st_nxt = dsq_pkg::ST_TK_LAST;
          end
        end
      end
      dsq_pkg::ST_TK_LAST: begin
        if (out_free) begin
          st_nxt = dsq_pkg::ST_IDLE;
        end
      end
      default: st_nxt = dsq_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory strobes and result loading
  always_comb begin
    occ_nxt        = occ_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    prev_nxt       = prev_r;
    t_nxt          = t_r;
    tid_nxt        = tid_r;
    hold_nxt       = hold_r;
    full_nxt       = full_r;
    cmd_ready      = 1'b0;
    rd_en          = 1'b0;
    rd_log         = '0;
    wr_en          = 1'b0;
    wr_log         = '0;
    wr_data        = rdata;
    out_load       = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_thread_nxt = out_thread_r;
    out_last_nxt   = out_last_r;
    case (st_r)
      dsq_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          t_nxt    = cmd_t_sat;
          tid_nxt  = cmd.tid;
          sum_nxt  = '0;
          idx_nxt  = '0;
          full_nxt = (occ_r == CW'(N)) ? dsq_pkg::STATUS_FULL : dsq_pkg::STATUS_OK;
          if (occ_r != '0) begin
            rd_en  = 1'b1;
            rd_log = '0;
          end
        end
      end
      dsq_pkg::ST_SCAN: begin
        sum_nxt = sum_add;
        if (found) begin
          pos_nxt  = idx_r;
          prev_nxt = sum_r;
          hold_nxt = rd_thr;
          if (!last_scan) begin
            // open a gap by copying entries up from the tail
            idx_nxt = occ_r;
            rd_en   = 1'b1;
            rd_log  = occ_r - CW'(1);
          end
        end else if (!last_scan) begin
          idx_nxt = cand;
          rd_en   = 1'b1;
          rd_log  = cand;
        end
      end
      dsq_pkg::ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_log  = idx_r;
        wr_data = rdata;
        if (idx_r > pos_r + CW'(2)) begin
          idx_nxt = idx_r - CW'(1);
          rd_en   = 1'b1;
          rd_log  = idx_r - CW'(2);
        end
      end
      dsq_pkg::ST_APPEND: begin
        wr_en   = 1'b1;
        wr_log  = occ_r;
        wr_data = {tid_r, t_r - sum_r};
        occ_nxt = occ_r + CW'(1);
      end
      dsq_pkg::ST_INS_NEXT: begin
        wr_en   = 1'b1;
        wr_log  = pos_r + CW'(1);
        wr_data = {hold_r, sum_r - t_r};
      end
      dsq_pkg::ST_INS_POS: begin
        wr_en   = 1'b1;
        wr_log  = pos_r;
        wr_data = {tid_r, t_r - prev_r};
        occ_nxt = occ_r + CW'(1);
      end
      dsq_pkg::ST_ACK: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = dsq_pkg::KIND_ACK;
          out_status_nxt = full_r;
          out_thread_nxt = '0;
          out_last_nxt   = 1'b1;
        end
      end
      dsq_pkg::ST_TK_HEAD: begin
        if (head_dec != '0) begin
          wr_en   = 1'b1;
          wr_log  = '0;
          wr_data = {rd_thr, head_dec};
        end else begin
          hold_nxt = rd_thr;
          idx_nxt  = cand;
          if (more) begin
            rd_en  = 1'b1;
            rd_log = cand;
          end
        end
      end
      dsq_pkg::ST_TK_SCAN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = dsq_pkg::KIND_WAKE;
          out_status_nxt = dsq_pkg::STATUS_OK;
          out_thread_nxt = hold_r;
          if (rd_delta == '0) begin
            out_last_nxt = 1'b0;
            hold_nxt     = rd_thr;
            idx_nxt      = cand;
            if (more) begin
              rd_en  = 1'b1;
              rd_log = cand;
            end
          end else begin
            out_last_nxt = 1'b1;
            head_nxt     = to_phys(head_r, (AW+1)'(idx_r));
            occ_nxt      = occ_r - idx_r;
          end
        end
      end
      dsq_pkg::ST_TK_LAST: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = dsq_pkg::KIND_WAKE;
          out_status_nxt = dsq_pkg::STATUS_OK;
          out_thread_nxt = hold_r;
          out_last_nxt   = 1'b1;
          head_nxt       = to_phys(head_r, (AW+1)'(idx_r));
          occ_nxt        = occ_r - idx_r;
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dsq_pkg::ST_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    sum_r        <= sum_nxt;
    prev_r       <= prev_nxt;
    t_r          <= t_nxt;
    tid_r        <= tid_nxt;
    hold_r       <= hold_nxt;
    full_r       <= full_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_thread_r <= out_thread_nxt;
    out_last_r   <= out_last_nxt;
  end

  dsq_ram #(
    .WIDTH (RW),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (to_phys(head_r, (AW+1)'(wr_log))),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (to_phys(head_r, (AW+1)'(rd_log))),
    .rdata (rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_thread = out_thread_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dsq_pkg::ST_ACK && full_r == dsq_pkg::STATUS_FULL) |-> occ_r == CW'(N))
    else $error("full status given with free slots");

  a_wake_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_kind_nxt == dsq_pkg::KIND_WAKE) |-> occ_r != '0)
    else $error("wake report from an empty queue");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dsq_pkg::ST_APPEND || st_r == dsq_pkg::ST_INS_POS)
      |=> occ_r == $past(occ_r) + CW'(1))
    else $error("insert did not grow the queue by one");
`endif

endmodule

`default_nettype wire

// File: rtl/core/delta_sleep_queue.sv
// delta_sleep_queue: top level of the delta-list sleep queue
// depends on dsq_pkg, dsq_front, dsq_back (and dsq_ram below it)
`default_nettype none

// Ordered queue of sleeping thread IDs kept as a delta list in a ring RAM.
// in_tuser = 0 inserts in_tdata's thread with its tick count and answers one
// acknowledgement word (ok, or full); in_tuser = 1 is a timer tick that answers
// one wake word per released thread, the final one with out_tlast high, and
// nothing when none is released. Requests are buffered two deep and run one at
// a time; the entry RAM is walked one entry per cycle, while no wake word waits on
// out_tready, through its single read port. A sleep that goes to the tail scans
// the list and appends; one that goes in front of an entry scans to the insert
// point, copies the tail up one slot, writes two entries and answers; a sleep on
// a full queue is answered without a scan. A tick counts down the head entry and
// hands over one wake word per released thread. The entry RAM needs no clearing
// after reset.
module delta_sleep_queue #(
  parameter int MAX_SLEEPERS = 16,
  parameter int DELAY_WIDTH  = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [7:0] thread_id, [39:8] sleep_ticks
  input  wire logic [dsq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] func
  input  wire logic                               in_tuser,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [0] status, [8:1] woken_thread, [15:9] zero
  output      logic [dsq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] kind
  output      logic                               out_tuser,
  output      logic                               out_tlast
);

  logic                      cmd_valid, cmd_ready;
  dsq_pkg::cmd_t             cmd;
  logic                      status;
  logic [dsq_pkg::TID_W-1:0] thread;

  dsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dsq_back #(
    .MAX_SLEEPERS (MAX_SLEEPERS),
    .DELAY_WIDTH  (DELAY_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (status),
    .out_thread (thread),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(dsq_pkg::OUT_TDATA_W - dsq_pkg::TID_W - 1){1'b0}}, thread, status};

endmodule

`default_nettype wire

// File: sim/tb_delta_sleep_queue.sv
// tb_delta_sleep_queue: self-checking testbench for the delta-list sleep queue
// drives sleep and tick words with random gaps and checks every reply against
// an in-bench model of the queue; depends on dsq_pkg and delta_sleep_queue
`default_nettype none

module tb_delta_sleep_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 16;
  localparam int STALL_LEN  = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 64;
  localparam int N_ITEMS    = 460;

  typedef struct {
    logic                        func;
    logic [dsq_pkg::TID_W-1:0]   tid;
    logic [dsq_pkg::TICKS_W-1:0] ticks;
    bit                          drain;
  } req_t;

  typedef struct {
    logic                      kind;
    logic                      status;
    logic [dsq_pkg::TID_W-1:0] tid;
    logic                      last;
  } reply_t;

  logic clk;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic in_tready;
  logic [dsq_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser   = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dsq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  delta_sleep_queue #(
    .MAX_SLEEPERS(SLOTS),
    .DELAY_WIDTH (dsq_pkg::TICKS_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // queue image kept by the bench
  logic [dsq_pkg::TID_W-1:0]   sleeper_tid [SLOTS];
  logic [dsq_pkg::TICKS_W-1:0] sleeper_dly [SLOTS];
  int                          sleeper_cnt;

  req_t   pending_reqs[$];
  reply_t due_replies[$];
  req_t   on_wire;
  bit     word_taken;
  bit     reply_taken;
  int     send_gap, send_run;
  int     recv_gap, recv_run;
  int     hold_left;
  int     hold_mark;
  int     replies_seen;
  int     idle_cycles;
  int     fails;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(inout int run);
    int r;
    r = $urandom_range(0, 99);
    if (run > 0) begin
      run--;
      return 0;
    end
    if (r < 3) begin
      run = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_req(logic func, logic [dsq_pkg::TID_W-1:0] tid,
                                  logic [dsq_pkg::TICKS_W-1:0] ticks, bit drain);
    req_t q;
    q.func  = func;
    q.tid   = tid;
    q.ticks = ticks;
    q.drain = drain;
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_reply(logic kind, logic status,
                                     logic [dsq_pkg::TID_W-1:0] tid, logic last);
    reply_t p;
    p.kind   = kind;
    p.status = status;
    p.tid    = tid;
    p.last   = last;
    due_replies.push_back(p);
  endfunction

  // insert into the delta list, ahead of any sleeper with the same deadline
  function automatic void book_sleep(logic [dsq_pkg::TID_W-1:0] tid,
                                     logic [dsq_pkg::TICKS_W-1:0] ticks);
    logic [dsq_pkg::TICKS_W-1:0] want, acc, acc_prev;
    int pos;
    bit found;
    if (sleeper_cnt >= SLOTS) begin
      push_reply(dsq_pkg::KIND_ACK, dsq_pkg::STATUS_FULL, '0, 1'b1);
      return;
    end
    want = (ticks == '0) ? dsq_pkg::TICKS_W'(1) : ticks;
    pos = sleeper_cnt;
    acc = '0;
    acc_prev = '0;
    found = 1'b0;
    for (int i = 0; i < sleeper_cnt; i++) begin
      if (!found) begin
        acc_prev = acc;
        acc = acc + sleeper_dly[i];
        if (acc >= want) begin
          pos = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      for (int i = sleeper_cnt; i > pos; i--) begin
        sleeper_tid[i] = sleeper_tid[i-1];
        sleeper_dly[i] = sleeper_dly[i-1];
      end
      sleeper_dly[pos+1] = acc - want;
      sleeper_dly[pos]   = want - acc_prev;
    end else begin
      sleeper_dly[pos] = want - acc;
    end
    sleeper_tid[pos] = tid;
    sleeper_cnt++;
    push_reply(dsq_pkg::KIND_ACK, dsq_pkg::STATUS_OK, '0, 1'b1);
  endfunction

  // one timer tick: count down the head and release every expired sleeper
  function automatic void advance_tick();
    int n;
    if (sleeper_cnt == 0) return;
    if (sleeper_dly[0] != '0) sleeper_dly[0] = sleeper_dly[0] - dsq_pkg::TICKS_W'(1);
    n = 0;
    while (n < sleeper_cnt && n < dsq_pkg::MAX_RESULTS && sleeper_dly[n] == '0) n++;
    for (int i = 0; i < n; i++)
      push_reply(dsq_pkg::KIND_WAKE, dsq_pkg::STATUS_OK, sleeper_tid[i], (i + 1 == n));
    for (int i = n; i < sleeper_cnt; i++) begin
      sleeper_tid[i-n] = sleeper_tid[i];
      sleeper_dly[i-n] = sleeper_dly[i];
    end
    sleeper_cnt -= n;
  endfunction

  // input side: a word is taken at the rising edge, the model follows it
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (on_wire.func == dsq_pkg::FUNC_SLEEP) book_sleep(on_wire.tid, on_wire.ticks);
      else advance_tick();
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain && due_replies.size() != 0)) begin
        on_wire = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {on_wire.ticks, on_wire.tid};
        in_tuser  <= on_wire.func;
        send_gap = pick_gap(send_run);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure plus a couple of long holds
  always @(negedge clk) begin
    if (rst_n) begin
      if (reply_taken) begin
        reply_taken = 1'b0;
        recv_gap = pick_gap(recv_run);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (replies_seen >= hold_mark) begin
        hold_left = STALL_LEN;
        hold_mark = (hold_mark < 200) ? 300 : 32'h7fff_ffff;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      reply_taken = 1'b1;
      if (due_replies.size() == 0) begin
        $error("unexpected word: kind %0d tdata %h last %0d", out_tuser, out_tdata,
               out_tlast);
        fails++;
      end else begin
        exp = due_replies.pop_front();
        if (out_tuser !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, out_tuser);
          fails++;
        end
        if (out_tdata[0] !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_tdata[0]);
          fails++;
        end
        if (out_tdata[8:1] !== exp.tid) begin
          $error("woken_thread: expected %0d, got %0d", exp.tid, out_tdata[8:1]);
          fails++;
        end
        if (out_tlast !== exp.last) begin
          $error("last: expected %0d, got %0d", exp.last, out_tlast);
          fails++;
        end
        if (out_tdata[15:9] !== '0) begin
          $error("pad: expected 0, got %h", out_tdata[15:9]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("delta_sleep_queue verification failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_len, tick_pct, r;
    logic [dsq_pkg::TICKS_W-1:0] t;
    sleeper_cnt  = 0;
    word_taken   = 1'b0;
    reply_taken  = 1'b0;
    send_gap     = 0;
    send_run     = 0;
    recv_gap     = 0;
    recv_run     = 0;
    hold_left    = 0;
    hold_mark    = 40;
    replies_seen = 0;
    idle_cycles  = 0;
    fails        = 0;

    // directed: empty tick, zero and all-ones counts, same deadline, full queue
    add_req(dsq_pkg::FUNC_TICK,  8'h5a, 32'h1234_5678, 1'b0);
    add_req(dsq_pkg::FUNC_SLEEP, 8'h00, 32'h0000_0000, 1'b0);
    add_req(dsq_pkg::FUNC_SLEEP, 8'hff, 32'hffff_ffff, 1'b0);
    add_req(dsq_pkg::FUNC_SLEEP, 8'haa, 32'h0000_0001, 1'b0);
    add_req(dsq_pkg::FUNC_TICK,  8'hff, 32'hffff_ffff, 1'b0);
    add_req(dsq_pkg::FUNC_TICK,  8'h00, 32'h0000_0000, 1'b0);
    for (int i = 0; i < SLOTS - 1; i++)
      add_req(dsq_pkg::FUNC_SLEEP, 8'(i * 17 + 1), 32'd3, (i == 0));
    add_req(dsq_pkg::FUNC_SLEEP, 8'h77, 32'd2, 1'b0);
    add_req(dsq_pkg::FUNC_TICK,  8'h00, 32'h0, 1'b1);
    add_req(dsq_pkg::FUNC_TICK,  8'h00, 32'h0, 1'b0);
    add_req(dsq_pkg::FUNC_TICK,  8'h00, 32'h0, 1'b0);

    // random phases that lean towards filling or towards draining the queue
    while (pending_reqs.size() < N_ITEMS) begin
      phase_len = $urandom_range(20, 50);
      r = $urandom_range(0, 2);
      tick_pct = (r == 0) ? 25 : (r == 1) ? 50 : 75;
      for (int i = 0; i < phase_len && pending_reqs.size() < N_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) t = '0;
        else if (r < 75) t = $urandom_range(1, 6);
        else if (r < 95) t = $urandom_range(7, 40);
        else t = $urandom_range(41, 200);
        add_req(($urandom_range(0, 99) < tick_pct) ? dsq_pkg::FUNC_TICK
                                                   : dsq_pkg::FUNC_SLEEP,
                8'($urandom_range(0, 255)), t, ($urandom_range(0, 99) < 2));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid || due_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fails == 0) begin
      $display("delta_sleep_queue verification clean");
    end else begin
      $display("delta_sleep_queue verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/dsq_pkg.sv
rtl/core/dsq_ram.sv
rtl/core/dsq_front.sv
rtl/core/dsq_back.sv
rtl/core/delta_sleep_queue.sv
sim/tb_delta_sleep_queue.sv
